### rtl/tds_pkg.sv
package tds_pkg;

    localparam int THRUST_WIDTH_DEF = 16;
    localparam int TURN_WIDTH_DEF   = 32;

    localparam int COEF_W  = 16;
    localparam int GAIN_W  = 24;
    localparam int OUT_W   = 32;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    // turn values are Q.16, coefficients Q.12, gains Q.24
    localparam int TURN_FRAC = 16;
    localparam int COEF_FRAC = 12;
    // thrust terms reframed to Q.16 never exceed +/-1.0
    localparam int TERM_W    = 18;

    localparam logic signed [COEF_W-1:0] COEF_PREV2_RST  = -16'sd3043;
    localparam logic signed [COEF_W-1:0] COEF_PREV1_RST  = 16'sd6726;
    localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = 16'sd16517;
    localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = -16'sd3150;
    localparam logic [GAIN_W-1:0]        SURGE_GAIN_RST  = 24'd2013266;
    localparam logic [GAIN_W-1:0]        YAW_GAIN_RST    = 24'd14876;

    typedef enum logic [2:0] {
        REG_COEF_PREV2  = 3'd0,
        REG_COEF_PREV1  = 3'd1,
        REG_COEF_SQUARE = 3'd2,
        REG_COEF_LINEAR = 3'd3,
        REG_SURGE_GAIN  = 3'd4,
        REG_YAW_GAIN    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MAC_PREP,
        MAC_PREV2,
        MAC_PREV1,
        MAC_SQUARE,
        MAC_LINEAR,
        MAC_HOLD
    } t_mac_phase;

    typedef struct packed {
        logic signed [COEF_W-1:0] prev2;
        logic signed [COEF_W-1:0] prev1;
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
    } t_coef;

    typedef struct packed {
        logic start;
        logic run;
        logic commit;
    } t_lane_ctl;

endpackage

### rtl/tds_if.sv
interface tds_in_if #(
    parameter int THRUST_WIDTH = tds_pkg::THRUST_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [THRUST_WIDTH-1:0] left_thrust;
    logic signed [THRUST_WIDTH-1:0] right_thrust;

    modport source (output valid, output left_thrust, output right_thrust, input ready);
    modport sink   (input valid, input left_thrust, input right_thrust, output ready);
endinterface

interface tds_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [tds_pkg::OUT_W-1:0] surge_force;
    logic signed [tds_pkg::OUT_W-1:0] yaw_moment;

    modport source (output valid, output surge_force, output yaw_moment, input ready);
    modport sink   (input valid, input surge_force, input yaw_moment, output ready);
endinterface

### rtl/thruster_dynamics_step.sv
// Two-thruster surge/yaw dynamics, one tick per input item. Each item carries a
// left and a right thrust command; the result is the surge force and yaw moment
// formed from the signed square roots of the turn values held before the item,
// after which each side's turn value is advanced by its second-order update.
// The two sides run in identical lanes that share one coefficient set, and a
// merge stage applies the gains. The time an item takes is set by the
// bit-serial square root, which resolves one root bit per cycle; the turn
// update's four coefficient multiplies run on one multiplier per lane in the
// shadow of the root. A finished result sits in an output register, so the
// next item can be accepted while it waits.
// Coefficients and gains must be written over the APB port only while no item
// is in flight; the block itself does not enforce this.
module thruster_dynamics_step #(
    parameter int THRUST_WIDTH = tds_pkg::THRUST_WIDTH_DEF,
    parameter int TURN_WIDTH   = tds_pkg::TURN_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tds_in_if.sink                         i_in,
    tds_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tds_pkg::APB_AW-1:0]     paddr,
    input  logic [tds_pkg::APB_DW-1:0]     pwdata,
    output logic [tds_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import tds_pkg::*;

    localparam int RH     = (TURN_WIDTH + 17) / 2;
    localparam int STEP_W = $clog2(RH);

    // configuration
    t_coef                r_coef;
    logic [GAIN_W-1:0]    r_surge_gain;
    logic [GAIN_W-1:0]    r_yaw_gain;
    t_reg_idx             reg_idx;
    logic                 cfg_wr;

    // sequencer
    t_state               r_state;
    t_state               n_state;
    logic [STEP_W-1:0]    r_step;
    logic                 in_ready;
    logic                 in_acc;
    logic                 out_free;
    logic                 mul_en;
    t_lane_ctl            lane_ctl;

    // datapath
    logic signed [RH:0]       root_l;
    logic signed [RH:0]       root_r;
    logic signed [OUT_W-1:0]  surge_nx;
    logic signed [OUT_W-1:0]  yaw_nx;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_surge;
    logic signed [OUT_W-1:0]  r_yaw;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.prev2  <= COEF_PREV2_RST;
            r_coef.prev1  <= COEF_PREV1_RST;
            r_coef.square <= COEF_SQUARE_RST;
            r_coef.linear <= COEF_LINEAR_RST;
            r_surge_gain  <= SURGE_GAIN_RST;
            r_yaw_gain    <= YAW_GAIN_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_COEF_PREV2:  r_coef.prev2  <= pwdata[COEF_W-1:0];
                REG_COEF_PREV1:  r_coef.prev1  <= pwdata[COEF_W-1:0];
                REG_COEF_SQUARE: r_coef.square <= pwdata[COEF_W-1:0];
                REG_COEF_LINEAR: r_coef.linear <= pwdata[COEF_W-1:0];
                REG_SURGE_GAIN:  r_surge_gain  <= pwdata[GAIN_W-1:0];
                REG_YAW_GAIN:    r_yaw_gain    <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COEF_PREV2:  prdata = APB_DW'($unsigned(r_coef.prev2));
            REG_COEF_PREV1:  prdata = APB_DW'($unsigned(r_coef.prev1));
            REG_COEF_SQUARE: prdata = APB_DW'($unsigned(r_coef.square));
            REG_COEF_LINEAR: prdata = APB_DW'($unsigned(r_coef.linear));
            REG_SURGE_GAIN:  prdata = APB_DW'(r_surge_gain);
            REG_YAW_GAIN:    prdata = APB_DW'(r_yaw_gain);
            default:         prdata = '0;
        endcase
    end

    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_in.valid ? ST_ROOT : ST_IDLE;
            ST_ROOT: n_state = (r_step == STEP_W'(RH - 1)) ? ST_MUL : ST_ROOT;
            ST_MUL:  n_state = ST_DONE;
            ST_DONE: n_state = out_free ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready        = (r_state == ST_IDLE);
        in_acc          = in_ready && i_in.valid;
        mul_en          = (r_state == ST_MUL);
        lane_ctl.start  = in_acc;
        lane_ctl.run    = (r_state == ST_ROOT);
        lane_ctl.commit = (r_state == ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ROOT) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    tds_lane #(
        .THRUST_WIDTH (THRUST_WIDTH),
        .TURN_WIDTH   (TURN_WIDTH)
    ) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_coef   (r_coef),
        .i_thrust (i_in.left_thrust),
        .o_root   (root_l)
    );

    tds_lane #(
        .THRUST_WIDTH (THRUST_WIDTH),
        .TURN_WIDTH   (TURN_WIDTH)
    ) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_coef   (r_coef),
        .i_thrust (i_in.right_thrust),
        .o_root   (root_r)
    );

    tds_merge #(
        .TURN_WIDTH (TURN_WIDTH)
    ) u_merge (
        .i_clk        (i_clk),
        .i_mul        (mul_en),
        .i_root_l     (root_l),
        .i_root_r     (root_r),
        .i_surge_gain (r_surge_gain),
        .i_yaw_gain   (r_yaw_gain),
        .o_surge      (surge_nx),
        .o_yaw        (yaw_nx)
    );

    // output register: holds a finished item while the next one is worked on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (lane_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctl.commit) begin
            r_surge <= surge_nx;
            r_yaw   <= yaw_nx;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.surge_force = r_surge;
    assign o_out.yaw_moment  = r_yaw;

endmodule

### rtl/tds_lane.sv
module tds_lane #(
    parameter int THRUST_WIDTH = tds_pkg::THRUST_WIDTH_DEF,
    parameter int TURN_WIDTH   = tds_pkg::TURN_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  tds_pkg::t_lane_ctl                   i_ctl,
    input  tds_pkg::t_coef                       i_coef,
    input  logic signed [THRUST_WIDTH-1:0]       i_thrust,
    output logic signed [(TURN_WIDTH+17)/2:0]    o_root
);
    import tds_pkg::*;

    localparam int TW   = THRUST_WIDTH;
    localparam int UW   = TURN_WIDTH;
    localparam int RH   = (UW + 17) / 2;     // root bits
    localparam int RW   = 2 * RH;            // radicand bits
    localparam int AW   = UW + COEF_W + 2;   // exact accumulator
    localparam int PW   = UW + COEF_W;       // coef * operand
    localparam int SQ_F = 2 * (TW - 1);
    localparam int SQ_L = (SQ_F < TURN_FRAC) ? TURN_FRAC - SQ_F : 0;
    localparam int SQ_R = (SQ_F < TURN_FRAC) ? 0 : SQ_F - TURN_FRAC;
    localparam int LN_F = TW - 1;
    localparam int LN_L = (LN_F < TURN_FRAC) ? TURN_FRAC - LN_F : 0;
    localparam int LN_R = (LN_F < TURN_FRAC) ? 0 : LN_F - TURN_FRAC;
    localparam int SQP  = 2 * TW + 2;
    localparam int SQX  = SQP + SQ_L;
    localparam int LNX  = TW + LN_L;
    localparam int SHW  = AW - COEF_FRAC;

    // history and item
    logic signed [TW-1:0]     r_thrust;
    logic signed [UW-1:0]     r_last;
    logic signed [UW-1:0]     r_before;
    logic signed [UW-1:0]     n_turn;

    // turn update datapath
    t_mac_phase               r_phase;
    logic signed [TERM_W-1:0] r_sq;
    logic signed [TERM_W-1:0] r_lin;
    logic signed [AW-1:0]     r_acc;
    logic signed [TW:0]       t_ext;
    logic signed [TW:0]       t_mag;
    logic signed [SQP-1:0]    sq_prod;
    logic signed [SQX-1:0]    sq_full;
    logic signed [LNX-1:0]    lin_full;
    logic signed [COEF_W-1:0] mac_coef;
    logic signed [UW-1:0]     mac_opnd;
    logic signed [PW-1:0]     mac_prod;
    logic signed [AW-1:0]     acc_rnd;
    logic signed [SHW-1:0]    acc_sh;
    logic                     acc_ovf;

    // bit-serial root
    logic [RW-1:0]            r_rad;
    logic [RH+1:0]            r_rem;
    logic [RH-1:0]            r_root;
    logic                     r_neg;
    logic [UW-1:0]            last_mag;
    logic [RH+3:0]            sq_cand;
    logic [RH+3:0]            sq_trial;
    logic [RH+3:0]            sq_diff;
    logic signed [RH:0]       root_s;

    assign t_ext    = (TW+1)'(r_thrust);
    assign t_mag    = t_ext[TW] ? -t_ext : t_ext;
    assign sq_prod  = SQP'(t_ext * t_mag);
    assign sq_full  = (SQX'(sq_prod) <<< SQ_L) >>> SQ_R;
    assign lin_full = (LNX'(r_thrust) <<< LN_L) >>> LN_R;

    always_comb begin
        case (r_phase)
            MAC_PREV2: begin
                mac_coef = i_coef.prev2;
                mac_opnd = r_before;
            end
            MAC_PREV1: begin
                mac_coef = i_coef.prev1;
                mac_opnd = r_last;
            end
            MAC_SQUARE: begin
                mac_coef = i_coef.square;
                mac_opnd = UW'(r_sq);
            end
            MAC_LINEAR: begin
                mac_coef = i_coef.linear;
                mac_opnd = UW'(r_lin);
            end
            default: begin
                mac_coef = '0;
                mac_opnd = '0;
            end
        endcase
    end

    assign mac_prod = PW'(mac_coef * mac_opnd);

    // round half up to Q.16, saturate to the turn width
    assign acc_rnd = r_acc + AW'(1 <<< (COEF_FRAC - 1));
    assign acc_sh  = acc_rnd[AW-1:COEF_FRAC];
    assign acc_ovf = (acc_sh[SHW-1:UW-1] != '0) && (acc_sh[SHW-1:UW-1] != '1);

    always_comb begin
        if (acc_ovf) begin
            n_turn = acc_sh[SHW-1] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
        end else begin
            n_turn = acc_sh[UW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_before <= '0;
            r_phase  <= MAC_HOLD;
        end else begin
            if (i_ctl.commit) begin
                r_before <= r_last;
                r_last   <= n_turn;
            end
            if (i_ctl.start) begin
                r_phase <= MAC_PREP;
            end else if (i_ctl.run && r_phase != MAC_HOLD) begin
                r_phase <= t_mac_phase'(r_phase + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_thrust <= i_thrust;
            r_acc    <= '0;
        end else if (i_ctl.run) begin
            if (r_phase == MAC_PREP) begin
                r_sq  <= sq_full[TERM_W-1:0];
                r_lin <= TERM_W'(lin_full);
            end else if (r_phase != MAC_HOLD) begin
                r_acc <= r_acc + AW'(mac_prod);
            end
        end
    end

    // root of the current last turn value, one result bit per step
    assign last_mag = r_last[UW-1] ? UW'(-r_last) : UW'(r_last);
    assign sq_cand  = {r_rem, r_rad[RW-1:RW-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_diff  = sq_cand - sq_trial;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rad  <= RW'({last_mag, {TURN_FRAC{1'b0}}});
            r_rem  <= '0;
            r_root <= '0;
            r_neg  <= r_last[UW-1];
        end else if (i_ctl.run) begin
            r_rad <= {r_rad[RW-3:0], 2'b00};
            if (sq_cand >= sq_trial) begin
                r_rem  <= sq_diff[RH+1:0];
                r_root <= {r_root[RH-2:0], 1'b1};
            end else begin
                r_rem  <= sq_cand[RH+1:0];
                r_root <= {r_root[RH-2:0], 1'b0};
            end
        end
    end

    assign root_s = {1'b0, r_root};
    assign o_root = r_neg ? -root_s : root_s;

endmodule

### rtl/tds_merge.sv
module tds_merge #(
    parameter int TURN_WIDTH = tds_pkg::TURN_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_mul,
    input  logic signed [(TURN_WIDTH+17)/2:0]    i_root_l,
    input  logic signed [(TURN_WIDTH+17)/2:0]    i_root_r,
    input  logic [tds_pkg::GAIN_W-1:0]           i_surge_gain,
    input  logic [tds_pkg::GAIN_W-1:0]           i_yaw_gain,
    output logic signed [tds_pkg::OUT_W-1:0]     o_surge,
    output logic signed [tds_pkg::OUT_W-1:0]     o_yaw
);
    import tds_pkg::*;

    localparam int RH = (TURN_WIDTH + 17) / 2;
    localparam int VW = RH + 2;
    localparam int PW = (RH + GAIN_W + 3 > 48) ? RH + GAIN_W + 3 : 48;
    localparam int SW = PW - TURN_FRAC;

    logic signed [VW-1:0]     root_sum;
    logic signed [VW-1:0]     root_dif;
    logic signed [GAIN_W:0]   surge_g;
    logic signed [GAIN_W:0]   yaw_g;
    logic signed [PW-1:0]     r_p_surge;
    logic signed [PW-1:0]     r_p_yaw;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] rnd;
        logic signed [SW-1:0] sh;
        rnd = p + PW'(1 <<< (TURN_FRAC - 1));
        sh  = rnd[PW-1:TURN_FRAC];
        if ((sh[SW-1:OUT_W-1] != '0) && (sh[SW-1:OUT_W-1] != '1)) begin
            round_sat = sh[SW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            round_sat = sh[OUT_W-1:0];
        end
    endfunction

    assign root_sum = VW'(i_root_l) + VW'(i_root_r);
    assign root_dif = VW'(i_root_l) - VW'(i_root_r);
    assign surge_g  = {1'b0, i_surge_gain};
    assign yaw_g    = {1'b0, i_yaw_gain};

    always_ff @(posedge i_clk) begin
        if (i_mul) begin
            r_p_surge <= PW'(surge_g * root_sum);
            r_p_yaw   <= PW'(yaw_g * root_dif);
        end
    end

    assign o_surge = round_sat(r_p_surge);
    assign o_yaw   = round_sat(r_p_yaw);

endmodule

### tb/tds_checker.sv
module tds_checker #(
    parameter int THRUST_W = tds_pkg::THRUST_WIDTH_DEF,
    parameter int TURN_W   = tds_pkg::TURN_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tds_in_if                          i_items,
    tds_out_if                         i_forces,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [tds_pkg::APB_AW-1:0] i_paddr,
    input  logic [tds_pkg::APB_DW-1:0] i_pwdata,
    input  logic [tds_pkg::APB_DW-1:0] i_prdata,
    input  logic                       i_pready,
    output int                         o_mismatches,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tds_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] surge;
        logic signed [OUT_W-1:0] yaw;
    } t_force_pair;

    t_coef               coefs;
    logic [GAIN_W-1:0]   surge_gain;
    logic [GAIN_W-1:0]   yaw_gain;
    longint              left_last, left_prev, right_last, right_prev;
    t_force_pair         pending_forces[$];
    int                  fails = 0;

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor(sqrt(|x| * 2^16)), one result bit per step, sign of x restored
    function automatic longint root_of_turn(longint x);
        longint unsigned rem, acc, probe;
        if (x == 0) return 0;
        rem = (x < 0) ? -x : x;
        rem = rem << TURN_FRAC;
        acc = 0;
        probe = 64'h4000_0000_0000_0000;
        repeat (32) begin
            if (rem >= acc + probe) begin
                rem = rem - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return (x < 0) ? -longint'(acc) : longint'(acc);
    endfunction

    // second-order turn update; sum kept exact at Q.28, rounded half up to Q.16
    function automatic longint advance_turn(longint older, longint newer,
                                            logic signed [THRUST_W-1:0] cmd);
        longint t, mag, sq, lin, acc;
        t   = cmd;
        mag = (t < 0) ? -t : t;
        sq  = (t * mag) >>> (2 * (THRUST_W - 1) - TURN_FRAC);
        lin = t <<< (TURN_FRAC - (THRUST_W - 1));
        acc = longint'(coefs.prev2) * older + longint'(coefs.prev1) * newer
            + longint'(coefs.square) * sq + longint'(coefs.linear) * lin
            + (64'sd1 <<< (COEF_FRAC - 1));
        return clamp(acc >>> COEF_FRAC, TURN_W);
    endfunction

    function automatic logic signed [OUT_W-1:0] scale_force(logic [GAIN_W-1:0] g, longint v);
        longint prod, lim;
        prod = longint'(g) * v + (64'sd1 <<< (TURN_FRAC - 1));
        lim  = clamp(prod >>> TURN_FRAC, OUT_W);
        return lim[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        t_force_pair       want, got;
        longint            root_l, root_r, next_l, next_r;
        logic [APB_DW-1:0] reg_want, reg_mask;
        if (!i_rst_n) begin
            coefs.prev2  = COEF_PREV2_RST;
            coefs.prev1  = COEF_PREV1_RST;
            coefs.square = COEF_SQUARE_RST;
            coefs.linear = COEF_LINEAR_RST;
            surge_gain   = SURGE_GAIN_RST;
            yaw_gain     = YAW_GAIN_RST;
            left_last    = 0;
            left_prev    = 0;
            right_last   = 0;
            right_prev   = 0;
            pending_forces.delete();
        end else begin
            if (i_forces.valid && i_forces.ready) begin
                got.surge = i_forces.surge_force;
                got.yaw   = i_forces.yaw_moment;
                if (pending_forces.size() == 0) begin
                    $display("%0t: unexpected item, expected none, got surge %0d yaw %0d",
                             $time, got.surge, got.yaw);
                    fails++;
                end else begin
                    want = pending_forces.pop_front();
                    if (got.surge !== want.surge) begin
                        $display("%0t: surge_force expected %0d, got %0d",
                                 $time, want.surge, got.surge);
                        fails++;
                    end
                    if (got.yaw !== want.yaw) begin
                        $display("%0t: yaw_moment expected %0d, got %0d",
                                 $time, want.yaw, got.yaw);
                        fails++;
                    end
                end
            end

            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                        REG_COEF_PREV2:  coefs.prev2  = i_pwdata[COEF_W-1:0];
                        REG_COEF_PREV1:  coefs.prev1  = i_pwdata[COEF_W-1:0];
                        REG_COEF_SQUARE: coefs.square = i_pwdata[COEF_W-1:0];
                        REG_COEF_LINEAR: coefs.linear = i_pwdata[COEF_W-1:0];
                        REG_SURGE_GAIN:  surge_gain   = i_pwdata[GAIN_W-1:0];
                        REG_YAW_GAIN:    yaw_gain     = i_pwdata[GAIN_W-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_mask = {{(APB_DW-COEF_W){1'b0}}, {COEF_W{1'b1}}};
                    case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                        REG_COEF_PREV2:  reg_want = APB_DW'(coefs.prev2);
                        REG_COEF_PREV1:  reg_want = APB_DW'(coefs.prev1);
                        REG_COEF_SQUARE: reg_want = APB_DW'(coefs.square);
                        REG_COEF_LINEAR: reg_want = APB_DW'(coefs.linear);
                        REG_SURGE_GAIN: begin
                            reg_want = APB_DW'(surge_gain);
                            reg_mask = {{(APB_DW-GAIN_W){1'b0}}, {GAIN_W{1'b1}}};
                        end
                        REG_YAW_GAIN: begin
                            reg_want = APB_DW'(yaw_gain);
                            reg_mask = {{(APB_DW-GAIN_W){1'b0}}, {GAIN_W{1'b1}}};
                        end
                        default:         reg_mask = '0;
                    endcase
                    if ((i_prdata & reg_mask) !== (reg_want & reg_mask)) begin
                        $display("%0t: register %0d read expected %0h, got %0h", $time,
                                 i_paddr[APB_AW-1:2], reg_want & reg_mask, i_prdata & reg_mask);
                        fails++;
                    end
                end
            end

            // outputs come from the turn values held before this item
            if (i_items.valid && i_items.ready) begin
                root_l     = root_of_turn(left_last);
                root_r     = root_of_turn(right_last);
                want.surge = scale_force(surge_gain, root_l + root_r);
                want.yaw   = scale_force(yaw_gain, root_l - root_r);
                pending_forces.push_back(want);
                next_l     = advance_turn(left_prev, left_last, i_items.left_thrust);
                next_r     = advance_turn(right_prev, right_last, i_items.right_thrust);
                left_prev  = left_last;
                left_last  = next_l;
                right_prev = right_last;
                right_last = next_r;
            end
        end
        o_mismatches <= fails;
        o_pending    <= pending_forces.size();
    end

endmodule

### tb/tb_thruster_dynamics_step.sv
module tb_thruster_dynamics_step;
    timeunit 1ns;
    timeprecision 1ps;

    import tds_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int SETTLE       = 60;
    localparam int REG_SLOTS    = 1 << (APB_AW - 2);
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                pending;
    int                cycles = 0;
    bit                no_idle = 1'b0;

    tds_in_if #(.THRUST_WIDTH(THRUST_WIDTH_DEF)) item_if ();
    tds_out_if                                   force_if ();

    thruster_dynamics_step #(
        .THRUST_WIDTH (THRUST_WIDTH_DEF),
        .TURN_WIDTH   (TURN_WIDTH_DEF)
    ) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (item_if),
        .o_out   (force_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tds_checker #(
        .THRUST_W (THRUST_WIDTH_DEF),
        .TURN_W   (TURN_WIDTH_DEF)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_items      (item_if),
        .i_forces     (force_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #10ns clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [THRUST_WIDTH_DEF-1:0] pick_thrust(
        logic [THRUST_WIDTH_DEF-1:0] held);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            case ($urandom_range(0, 4))
                0:       return {1'b1, {(THRUST_WIDTH_DEF-1){1'b0}}};
                1:       return {1'b0, {(THRUST_WIDTH_DEF-1){1'b1}}};
                2:       return '0;
                3:       return '1;
                default: return THRUST_WIDTH_DEF'(1);
            endcase
        end
        if (r < 30) return held;
        return THRUST_WIDTH_DEF'($urandom());
    endfunction

    // upper bits beyond the register width carry noise
    function automatic logic [APB_DW-1:0] with_junk(logic [APB_DW-1:0] v, int w);
        logic [APB_DW-1:0] mask;
        mask = (APB_DW'(1) << w) - 1;
        return (APB_DW'($urandom()) & ~mask) | (v & mask);
    endfunction

    // output side: random stalls
    initial begin
        int stall, hold;
        force_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            stall = no_idle ? 0 : idle_len();
            if (stall > 0) begin
                force_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            force_if.ready <= 1'b1;
            hold = $urandom_range(0, 6);
            repeat (hold) @(posedge clk);
        end
    end

    task automatic push_item(input logic [THRUST_WIDTH_DEF-1:0] left,
                             input logic [THRUST_WIDTH_DEF-1:0] right);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid        <= 1'b1;
        item_if.left_thrust  <= left;
        item_if.right_thrust <= right;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic apb_access(input bit write_en, input logic [2:0] idx,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic load_config(input logic [COEF_W-1:0] p2, input logic [COEF_W-1:0] p1,
                               input logic [COEF_W-1:0] sq, input logic [COEF_W-1:0] ln,
                               input logic [GAIN_W-1:0] sg, input logic [GAIN_W-1:0] yg);
        apb_access(1'b1, REG_COEF_PREV2, with_junk(APB_DW'(p2), COEF_W));
        apb_access(1'b1, REG_COEF_PREV1, with_junk(APB_DW'(p1), COEF_W));
        apb_access(1'b1, REG_COEF_SQUARE, with_junk(APB_DW'(sq), COEF_W));
        apb_access(1'b1, REG_COEF_LINEAR, with_junk(APB_DW'(ln), COEF_W));
        apb_access(1'b1, REG_SURGE_GAIN, with_junk(APB_DW'(sg), GAIN_W));
        apb_access(1'b1, REG_YAW_GAIN, with_junk(APB_DW'(yg), GAIN_W));
        // writes to unmapped slots must leave everything alone
        apb_access(1'b1, REG_SPARE_LO, $urandom());
        apb_access(1'b1, REG_SPARE_HI, $urandom());
        for (int i = 0; i < REG_SLOTS; i++)
            apb_access(1'b0, i[2:0], pwdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        logic [THRUST_WIDTH_DEF-1:0] hold_l, hold_r;
        int a2, a1_span, a1;
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_if.valid        <= 1'b0;
        item_if.left_thrust  <= '0;
        item_if.right_thrust <= '0;
        hold_l = '0;
        hold_r = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero roots from the cleared state, full-scale commands
        push_item(16'sd0, 16'sd0);
        push_item(16'sd0, 16'sd0);
        push_item(16'sd32767, 16'sd32767);
        push_item(-16'sd32768, -16'sd32768);
        push_item(16'sd32767, -16'sd32768);
        push_item(-16'sd32768, 16'sd32767);
        push_item(16'sd1, -16'sd1);
        push_item(-16'sd1, 16'sd1);
        push_item(16'sd16384, -16'sd16384);
        push_item(-16'sd32768, 16'sd0);
        push_item(16'sd0, 16'sd32767);
        push_item(16'sd0, 16'sd0);
        push_item(16'sd0, 16'sd0);
        push_item(16'sd0, 16'sd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            // stop offering items so nothing is in flight during the writes
            item_if.valid <= 1'b0;
            drain();
            case (phase)
                0: load_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, '1, '1);
                1: load_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, '0, '0);
                2: load_config('0, '0, '0, '0, '1, '1);
                3: load_config(COEF_PREV2_RST, COEF_PREV1_RST, COEF_SQUARE_RST,
                               COEF_LINEAR_RST, SURGE_GAIN_RST, YAW_GAIN_RST);
                6: load_config(COEF_W'($urandom()), COEF_W'($urandom()),
                               COEF_W'($urandom()), COEF_W'($urandom()),
                               GAIN_W'($urandom()), GAIN_W'($urandom()));
                default: begin
                    // keep the turn recursion stable so the state stays in range
                    a2      = int'($urandom_range(0, 7600)) - 3800;
                    a1_span = 4096 - a2 - 64;
                    a1      = int'($urandom_range(0, 2 * a1_span)) - a1_span;
                    load_config(a2[COEF_W-1:0], a1[COEF_W-1:0], COEF_W'($urandom()),
                                COEF_W'($urandom()), GAIN_W'($urandom()),
                                GAIN_W'($urandom()));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                hold_l = pick_thrust(hold_l);
                hold_r = pick_thrust(hold_r);
                push_item(hold_l, hold_r);
            end
        end
        item_if.valid <= 1'b0;

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
